[rtl/contact_impulse_resolver_defines.svh]
// Assertion macros of the contact impulse resolver, used by the divider cir_div.
`ifndef CONTACT_IMPULSE_RESOLVER_DEFINES_SVH
`define CONTACT_IMPULSE_RESOLVER_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled while rst is high.
`define CIR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("contact impulse resolver assertion failed");

// Next-cycle implication, checked on clk and disabled while rst is high.
`define CIR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("contact impulse resolver assertion failed");

`endif

[rtl/cir_pkg.sv]
// Package with beat types, constants and helpers of the contact impulse resolver.
`timescale 1ns / 1ps
package cir_pkg;

  localparam int QUO_W = 31;
  localparam int NUM_W = 56;
  localparam int SUM_W = 33;
  localparam int REM_W = 64;
  localparam int CH_W = 50;
  localparam int ADDR_W = 3;
  localparam logic [8:0] RESTITUTION_RESET = 9'd256;
  localparam logic REG_RESTITUTION = 1'b0;
  localparam logic [QUO_W-1:0] MAG_LIMIT = {QUO_W{1'b1}};

  typedef struct packed {
    logic signed [31:0] vel_a_x;
    logic signed [31:0] vel_a_y;
    logic signed [31:0] vel_a_z;
    logic signed [31:0] vel_b_x;
    logic signed [31:0] vel_b_y;
    logic signed [31:0] vel_b_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [31:0] inv_mass_a;
    logic [31:0] inv_mass_b;
    logic signed [31:0] penetration_depth;
  } cir_in_t;

  typedef struct packed {
    logic signed [31:0] new_vel_a_x;
    logic signed [31:0] new_vel_a_y;
    logic signed [31:0] new_vel_a_z;
    logic signed [31:0] new_vel_b_x;
    logic signed [31:0] new_vel_b_y;
    logic signed [31:0] new_vel_b_z;
    logic signed [31:0] move_a_x;
    logic signed [31:0] move_a_y;
    logic signed [31:0] move_a_z;
    logic signed [31:0] move_b_x;
    logic signed [31:0] move_b_y;
    logic signed [31:0] move_b_z;
  } cir_out_t;

  typedef struct packed {
    logic [2:0][31:0] va;
    logic [2:0][31:0] vb;
    logic [2:0][15:0] n;
    logic [31:0] ima;
    logic [31:0] imb;
  } cir_side_t;

  typedef struct packed {
    cir_side_t side;
    logic [SUM_W-1:0] sum;
    logic [NUM_W-1:0] num_imp;
    logic [NUM_W-1:0] num_mov;
  } cir_div_in_t;

  typedef struct packed {
    cir_side_t side;
    logic [QUO_W-1:0] imp;
    logic [QUO_W-1:0] mov;
  } cir_div_out_t;

  function automatic logic [31:0] sat32(input logic signed [50:0] v);
    logic [31:0] r;
    if (v > 51'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -51'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[rtl/cir_front.sv]
// Front stages: separating speed, inverse mass sum and divider numerators.
`timescale 1ns / 1ps
module cir_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [8:0]            restitution,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  cir_pkg::cir_in_t      up_data,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output cir_pkg::cir_div_in_t  dn_data
);

  localparam int N = 3;

  logic [N-1:0] vld;
  logic [N-1:0] en;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      en[i] = dn_ready || (((~vld) >> i) != '0);
    end
  end

  assign up_ready = en[0];
  assign dn_valid = vld[N-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= up_valid;
      for (int i = 1; i < N; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  cir_pkg::cir_side_t side_in;
  logic [2:0][48:0] p_next;
  logic [cir_pkg::SUM_W-1:0] sum_next;

  always_comb begin
    logic signed [48:0] d;
    logic signed [48:0] m;
    side_in.va = {up_data.vel_a_z, up_data.vel_a_y, up_data.vel_a_x};
    side_in.vb = {up_data.vel_b_z, up_data.vel_b_y, up_data.vel_b_x};
    side_in.n = {up_data.normal_z, up_data.normal_y, up_data.normal_x};
    side_in.ima = up_data.inv_mass_a;
    side_in.imb = up_data.inv_mass_b;
    for (int i = 0; i < 3; i++) begin
      d = 49'($signed(side_in.va[i])) - 49'($signed(side_in.vb[i]));
      m = 49'($signed(side_in.n[i]));
      p_next[i] = d * m;
    end
    sum_next = {1'b0, up_data.inv_mass_a} + {1'b0, up_data.inv_mass_b};
  end

  cir_pkg::cir_side_t s0_side;
  logic [2:0][48:0] s0_p;
  logic [cir_pkg::SUM_W-1:0] s0_sum;
  logic signed [31:0] s0_depth;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_side <= side_in;
      s0_p <= p_next;
      s0_sum <= sum_next;
      s0_depth <= up_data.penetration_depth;
    end
  end

  logic signed [50:0] acc;
  logic signed [50:0] acc_adj;
  logic signed [36:0] s_next;
  logic imp_en_next;
  logic mov_en_next;

  always_comb begin
    acc = 51'($signed(s0_p[0])) + 51'($signed(s0_p[1])) + 51'($signed(s0_p[2]));
    acc_adj = acc + (acc[50] ? 51'sd16383 : 51'sd0);
    s_next = acc_adj[50:14];
    imp_en_next = (s_next[36] || (s_next == '0)) && (s0_sum != '0);
    mov_en_next = !s0_depth[31] && (s0_depth != '0) && (s0_sum != '0);
  end

  cir_pkg::cir_side_t s1_side;
  logic [cir_pkg::SUM_W-1:0] s1_sum;
  logic signed [31:0] s1_depth;
  logic signed [36:0] s1_s;
  logic s1_imp_en;
  logic s1_mov_en;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_side <= s0_side;
      s1_sum <= s0_sum;
      s1_depth <= s0_depth;
      s1_s <= s_next;
      s1_imp_en <= imp_en_next;
      s1_mov_en <= mov_en_next;
    end
  end

  logic [36:0] neg_s;
  logic [9:0] coef;
  logic [45:0] prod;

  always_comb begin
    neg_s = 37'd0 - s1_s;
    coef = 10'd256 + 10'(restitution);
    prod = 46'(neg_s[35:0]) * 46'(coef);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      dn_data.side <= s1_side;
      dn_data.sum <= s1_sum;
      dn_data.num_imp <= s1_imp_en ? cir_pkg::NUM_W'({prod, 8'b0}) : '0;
      dn_data.num_mov <= s1_mov_en ? cir_pkg::NUM_W'({s1_depth[30:0], 16'b0}) : '0;
    end
  end

endmodule

[rtl/cir_div.sv]
// Pipelined restoring divider for the impulse and move magnitudes, one bit per stage.
`timescale 1ns / 1ps
`include "contact_impulse_resolver_defines.svh"
module cir_div (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  cir_pkg::cir_div_in_t  up_data,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output cir_pkg::cir_div_out_t dn_data
);

  localparam int N = cir_pkg::QUO_W + 1;
  localparam int RW = cir_pkg::REM_W;
  localparam int QW = cir_pkg::QUO_W;

  logic [N-1:0] vld;
  logic [N-1:0] en;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      en[i] = dn_ready || (((~vld) >> i) != '0);
    end
  end

  assign up_ready = en[0];
  assign dn_valid = vld[N-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= up_valid;
      for (int i = 1; i < N; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  cir_pkg::cir_side_t side_r [N];
  logic [cir_pkg::SUM_W-1:0] sum_r [N];
  logic [RW-1:0] rem_i [N];
  logic [RW-1:0] rem_m [N];
  logic [QW-1:0] q_i [N];
  logic [QW-1:0] q_m [N];
  logic sat_i [N];
  logic sat_m [N];

  logic [RW-1:0] top_div;
  assign top_div = RW'(up_data.sum) << QW;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      side_r[0] <= up_data.side;
      sum_r[0] <= up_data.sum;
      rem_i[0] <= RW'(up_data.num_imp);
      rem_m[0] <= RW'(up_data.num_mov);
      q_i[0] <= '0;
      q_m[0] <= '0;
      sat_i[0] <= (up_data.num_imp != '0) && (RW'(up_data.num_imp) >= top_div);
      sat_m[0] <= (up_data.num_mov != '0) && (RW'(up_data.num_mov) >= top_div);
    end
  end

  for (genvar j = 1; j < N; j++) begin : g_bit
    localparam int B = N - 1 - j;
    logic [RW-1:0] dv;
    logic ge_i;
    logic ge_m;
    assign dv = RW'(sum_r[j-1]) << B;
    assign ge_i = rem_i[j-1] >= dv;
    assign ge_m = rem_m[j-1] >= dv;
    always_ff @(posedge clk) begin
      if (en[j]) begin
        side_r[j] <= side_r[j-1];
        sum_r[j] <= sum_r[j-1];
        rem_i[j] <= ge_i ? rem_i[j-1] - dv : rem_i[j-1];
        rem_m[j] <= ge_m ? rem_m[j-1] - dv : rem_m[j-1];
        q_i[j] <= q_i[j-1] | (ge_i ? (QW'(1) << B) : '0);
        q_m[j] <= q_m[j-1] | (ge_m ? (QW'(1) << B) : '0);
        sat_i[j] <= sat_i[j-1];
        sat_m[j] <= sat_m[j-1];
      end
    end
  end

  always_comb begin
    dn_data.side = side_r[N-1];
    dn_data.imp = sat_i[N-1] ? cir_pkg::MAG_LIMIT : q_i[N-1];
    dn_data.mov = sat_m[N-1] ? cir_pkg::MAG_LIMIT : q_m[N-1];
  end

  `CIR_ASSERT_IMP(a_rem_imp, vld[N-1] && !sat_i[N-1] && (sum_r[N-1] != '0), rem_i[N-1] < RW'(sum_r[N-1]))
  `CIR_ASSERT_IMP(a_rem_mov, vld[N-1] && !sat_m[N-1] && (sum_r[N-1] != '0), rem_m[N-1] < RW'(sum_r[N-1]))
  `CIR_ASSERT_IMP(a_full_stall, (&vld) && !dn_ready, !up_ready)
  `CIR_ASSERT_NEXT(a_hold_last, vld[N-1] && !dn_ready, vld[N-1] && $stable(q_i[N-1]))

endmodule

[rtl/cir_back.sv]
// Back stages: per-axis velocity and position changes, sums and saturation.
`timescale 1ns / 1ps
module cir_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  cir_pkg::cir_div_out_t up_data,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output cir_pkg::cir_out_t     dn_data
);

  localparam int N = 4;
  localparam int CW = cir_pkg::CH_W;

  logic [N-1:0] vld;
  logic [N-1:0] en;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      en[i] = dn_ready || (((~vld) >> i) != '0);
    end
  end

  assign up_ready = en[0];
  assign dn_valid = vld[N-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= up_valid;
      for (int i = 1; i < N; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // Lanes: impulse with A, impulse with B, move with A, move with B.
  logic [3:0][46:0] k_next;

  always_comb begin
    logic [62:0] pr;
    for (int l = 0; l < 4; l++) begin
      pr = 63'(l < 2 ? up_data.imp : up_data.mov) *
           63'(l[0] ? up_data.side.imb : up_data.side.ima);
      k_next[l] = pr[62:16];
    end
  end

  cir_pkg::cir_side_t s0_side;
  logic [3:0][46:0] s0_k;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_side <= up_data.side;
      s0_k <= k_next;
    end
  end

  logic [11:0][63:0] c_next;

  always_comb begin
    logic signed [63:0] kk;
    logic signed [63:0] nn;
    for (int l = 0; l < 4; l++) begin
      for (int a = 0; a < 3; a++) begin
        kk = 64'($signed({1'b0, s0_k[l]}));
        nn = 64'($signed(s0_side.n[a]));
        c_next[l*3+a] = kk * nn;
      end
    end
  end

  logic [2:0][31:0] s1_va;
  logic [2:0][31:0] s1_vb;
  logic [11:0][63:0] s1_c;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_va <= s0_side.va;
      s1_vb <= s0_side.vb;
      s1_c <= c_next;
    end
  end

  logic [11:0][CW-1:0] ch_next;

  always_comb begin
    logic signed [63:0] adj;
    for (int i = 0; i < 12; i++) begin
      adj = $signed(s1_c[i]) + (s1_c[i][63] ? 64'sd16383 : 64'sd0);
      ch_next[i] = adj[63:14];
    end
  end

  logic [2:0][31:0] s2_va;
  logic [2:0][31:0] s2_vb;
  logic [11:0][CW-1:0] s2_ch;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_va <= s1_va;
      s2_vb <= s1_vb;
      s2_ch <= ch_next;
    end
  end

  logic [11:0][31:0] res_next;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      res_next[a] = cir_pkg::sat32(51'($signed(s2_va[a])) + 51'($signed(s2_ch[a])));
      res_next[3+a] = cir_pkg::sat32(51'($signed(s2_vb[a])) - 51'($signed(s2_ch[3+a])));
      res_next[6+a] = cir_pkg::sat32(51'($signed(s2_ch[6+a])));
      res_next[9+a] = cir_pkg::sat32(51'sd0 - 51'($signed(s2_ch[9+a])));
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      dn_data.new_vel_a_x <= res_next[0];
      dn_data.new_vel_a_y <= res_next[1];
      dn_data.new_vel_a_z <= res_next[2];
      dn_data.new_vel_b_x <= res_next[3];
      dn_data.new_vel_b_y <= res_next[4];
      dn_data.new_vel_b_z <= res_next[5];
      dn_data.move_a_x <= res_next[6];
      dn_data.move_a_y <= res_next[7];
      dn_data.move_a_z <= res_next[8];
      dn_data.move_b_x <= res_next[9];
      dn_data.move_b_y <= res_next[10];
      dn_data.move_b_z <= res_next[11];
    end
  end

endmodule

[rtl/contact_impulse_resolver.sv]
// Top level of the contact impulse resolver: register port and pipeline chain.
// The contact channel takes one contact per beat (contact_valid/contact_ready,
// payload contact) and the result channel gives one resolved result per beat
// (result_valid/result_ready, payload result), in the same order.
// A contact passes through 3 front stages, 32 divider stages (an input stage,
// then one stage for each of the 31 quotient bits of the restoring divider),
// and 4 back stages.
// Throughput is one contact per cycle while the receiver keeps result_ready high.
// Every stage carries a valid bit; a stage moves whenever it is empty or the
// stage after it moves, so bubbles close up and a stalled receiver holds the
// last result while earlier stages keep filling. Input is refused only once
// every stage holds a contact.
// The restitution register sits at byte address 0 of the APB-style port; the
// user must write it only while the pipeline is empty; the block does not enforce it.
// Synchronous reset empties the pipeline and sets restitution to 1.0.
`timescale 1ns / 1ps
module contact_impulse_resolver (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cir_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          contact_valid,
  output logic                          contact_ready,
  input  cir_pkg::cir_in_t              contact,
  output logic                          result_valid,
  input  logic                          result_ready,
  output cir_pkg::cir_out_t             result
);

  logic [8:0] restitution;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      restitution <= cir_pkg::RESTITUTION_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == cir_pkg::REG_RESTITUTION)) begin
      restitution <= pwdata[8:0];
    end
  end

  assign prdata = (paddr[2] == cir_pkg::REG_RESTITUTION) ? {23'b0, restitution} : '0;

  logic f_valid;
  logic f_ready;
  cir_pkg::cir_div_in_t f_data;
  logic d_valid;
  logic d_ready;
  cir_pkg::cir_div_out_t d_data;

  cir_front u_front (
    .clk         (clk),
    .rst         (rst),
    .restitution (restitution),
    .up_valid    (contact_valid),
    .up_ready    (contact_ready),
    .up_data     (contact),
    .dn_valid    (f_valid),
    .dn_ready    (f_ready),
    .dn_data     (f_data)
  );

  cir_div u_div (
    .clk      (clk),
    .rst      (rst),
    .up_valid (f_valid),
    .up_ready (f_ready),
    .up_data  (f_data),
    .dn_valid (d_valid),
    .dn_ready (d_ready),
    .dn_data  (d_data)
  );

  cir_back u_back (
    .clk      (clk),
    .rst      (rst),
    .up_valid (d_valid),
    .up_ready (d_ready),
    .up_data  (d_data),
    .dn_valid (result_valid),
    .dn_ready (result_ready),
    .dn_data  (result)
  );

endmodule
